### sv/severity_priority_queue_server_assert.svh
// ----------------------------------------------------------------------------
// Severity priority queue server: assertion macros
// Clocked on clock and disabled during reset in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef SEVERITY_PRIORITY_QUEUE_SERVER_ASSERT_SVH
`define SEVERITY_PRIORITY_QUEUE_SERVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge
`define SPQS_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define SPQS_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SPQS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SPQS_ASSERT_ALWAYS(lbl, expr)
`define SPQS_ASSERT_IMPLY(lbl, ante, cons)
`define SPQS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/spqs_pkg.sv
// ----------------------------------------------------------------------------
// Severity priority queue server: shared package
// Slot layout, cell commands, controller states and the rank compare.
// ----------------------------------------------------------------------------
`default_nettype none

package spqs_pkg;

   // one waiting request
   typedef struct packed {
      logic [15:0] id;
      logic [6:0]  age;
      logic [5:0]  severity;
   } slot_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_left;
      logic insert;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SERVE,
      ST_INSERT
   } state_type;

   // request kinds
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_RESTORE = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_NORMAL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_URGENT = 1'b1;

   localparam logic [7:0] SERVICE_NORMAL_RESET = 8'd10;
   localparam logic [7:0] SERVICE_URGENT_RESET = 8'd5;

   // vulnerable age band limits
   localparam logic [6:0] AGE_YOUNG_LIMIT = 7'd10;
   localparam logic [6:0] AGE_OLD_LIMIT   = 7'd55;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;

   function automatic logic is_vulnerable(input logic [6:0] age);
      return (age < AGE_YOUNG_LIMIT) || (age > AGE_OLD_LIMIT);
   endfunction

   // true when a strictly outranks b
   function automatic logic outranks(input slot_type a, input slot_type b);
      logic res;
      if (a.severity != b.severity) begin
         res = a.severity > b.severity;
      end else begin
         res = is_vulnerable(a.age) && !is_vulnerable(b.age);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### sv/spqs_cell.sv
// ----------------------------------------------------------------------------
// Severity priority queue server: queue cell
// Holds one slot; shifts toward the head on a pop and makes room on an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spqs_cell
   import spqs_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire slot_type         new_slot,
   input  wire logic [CNT_W-1:0] count,
   input  wire slot_type         left_slot,
   input  wire logic             left_takes,
   input  wire slot_type         right_slot,
   output slot_type              slot,
   output logic                  takes
);

   slot_type slot_ff;
   logic     valid;

   // an empty cell or a lower-ranked entry lets the new item in
   assign valid = CNT_W'(INDEX) < count;
   assign takes = !valid || outranks(new_slot, slot_ff);
   assign slot  = slot_ff;

   // pop pulls from the right, insert pushes from the left
   always_ff @(posedge clock) begin
      if (cmd.shift_left) begin
         slot_ff <= right_slot;
      end else if (cmd.insert) begin
         if (left_takes) begin
            slot_ff <= left_slot;
         end else if (takes) begin
            slot_ff <= new_slot;
         end
      end
   end

endmodule

`default_nettype wire

### sv/spqs_chain.sv
// ----------------------------------------------------------------------------
// Severity priority queue server: cell chain
// Row of queue cells sorted by rank, head in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "severity_priority_queue_server_assert.svh"

module spqs_chain
   import spqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int CNT_W       = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_cmd_type     cmd,
   input  wire slot_type         new_slot,
   input  wire logic [CNT_W-1:0] count,
   output slot_type              head_slot
);

   slot_type cell_slot  [QUEUE_DEPTH];
   logic     cell_takes [QUEUE_DEPTH];

   // link each cell to its neighbors; the ends see fixed values
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type left_slot;
      logic     left_takes;
      slot_type right_slot;

      if (i == 0) begin : g_first
         assign left_slot  = '0;
         assign left_takes = 1'b0;
      end else begin : g_inner_left
         assign left_slot  = cell_slot[i-1];
         assign left_takes = cell_takes[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_inner_right
         assign right_slot = cell_slot[i+1];
      end

      spqs_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_slot   (new_slot),
         .count      (count),
         .left_slot  (left_slot),
         .left_takes (left_takes),
         .right_slot (right_slot),
         .slot       (cell_slot[i]),
         .takes      (cell_takes[i])
      );
   end

   assign head_slot = cell_slot[0];

   // the second entry never outranks the head
   `SPQS_ASSERT_IMPLY(a_head_sorted, count >= CNT_W'(2), !outranks(cell_slot[1], cell_slot[0]))

endmodule

`default_nettype wire

### sv/severity_priority_queue_server.sv
// ----------------------------------------------------------------------------
// Severity priority queue server: top level
// Sorted request queue with a timed server and one result per item.
// ----------------------------------------------------------------------------
// Each item passes through a serve cycle that advances the clock on an arrival
// and pops the head when it is due, then an insert cycle in which every cell of
// the chain compares the new item against its own entry and, unless the queue
// is full, the row shifts by one to make room. The next item is taken in the
// insert cycle, so items stream back to back while the output register is free;
// a result waiting in the output register holds the insert cycle until it is
// taken. The result carries the served entry (zeros when none), the drop flag,
// the queue count and the two saturating totals, all as of the end of the item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "severity_priority_queue_server_assert.svh"

module severity_priority_queue_server
   import spqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: op
   input  wire logic                   req_tuser,
   // request: entry_id, age, severity, elapsed, urgent_mode
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // result: served, served_id, served_age, served_severity, dropped,
   //         queue_count, entered_total, served_total
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type    state_ff, state_in;
   slot_type     item_ff;
   logic         op_ff;
   logic [7:0]   gap_ff;
   logic         urgent_ff;
   logic [7:0]   st_normal_ff;
   logic [7:0]   st_urgent_ff;
   logic [31:0]  clock_ff, clock_in;
   logic [31:0]  free_ff;
   logic [31:0]  arrivals_ff, arrivals_in;
   logic [31:0]  served_cnt_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic         serve_ff;
   slot_type     served_slot_ff;
   logic         rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic         serve_step, insert_step, out_free, serve_now, full;
   logic [32:0]  clock_sum, free_sum;
   logic [31:0]  free_new;
   logic [CNT_W+6:0] count_ext;
   cell_cmd_type cmd;
   slot_type     head_slot;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SERVE;
         end
         ST_SERVE: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (out_free) state_in = req_tvalid ? ST_SERVE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready  = 1'b0;
      serve_step  = 1'b0;
      insert_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SERVE: begin
            serve_step = 1'b1;
         end
         ST_INSERT: begin
            insert_step = out_free;
            req_tready  = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // advance the clock and decide on a pop
   always_comb begin
      clock_sum = {1'b0, clock_ff} + 33'(gap_ff);
      clock_in  = clock_ff;
      if (op_ff == OP_ARRIVAL) begin
         clock_in = clock_sum[32] ? '1 : clock_sum[31:0];
      end
      serve_now = (op_ff == OP_ARRIVAL) && (count_ff != '0) && (clock_in >= free_ff);
   end

   // busy window after a pop, count and arrivals after the insert
   always_comb begin
      free_sum    = {1'b0, clock_ff} + 33'(urgent_ff ? st_urgent_ff : st_normal_ff);
      free_new    = free_sum[32] ? '1 : free_sum[31:0];
      count_in    = full ? count_ff : count_ff + CNT_W'(1);
      arrivals_in = arrivals_ff;
      if (!full && op_ff == OP_ARRIVAL && !(&arrivals_ff)) begin
         arrivals_in = arrivals_ff + 32'd1;
      end
      count_ext   = {7'd0, count_in};
   end

   assign cmd = '{shift_left: serve_step && serve_now, insert: insert_step && !full};

   spqs_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .new_slot  (item_ff),
      .count     (count_ff),
      .head_slot (head_slot)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         st_normal_ff  <= SERVICE_NORMAL_RESET;
         st_urgent_ff  <= SERVICE_URGENT_RESET;
         clock_ff      <= '0;
         free_ff       <= '0;
         arrivals_ff   <= '0;
         served_cnt_ff <= '0;
         count_ff      <= '0;
         serve_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SERVICE_NORMAL: st_normal_ff <= csr_data;
               CSR_SERVICE_URGENT: st_urgent_ff <= csr_data;
               default: ;
            endcase
         end

         // serve cycle: clock, pop
         if (serve_step) begin
            clock_ff <= clock_in;
            serve_ff <= serve_now;
            if (serve_now) begin
               count_ff <= count_ff - CNT_W'(1);
               if (!(&served_cnt_ff)) served_cnt_ff <= served_cnt_ff + 32'd1;
            end
         end

         // insert cycle: busy window, insert, result
         if (insert_step) begin
            if (serve_ff) free_ff <= free_new;
            count_ff    <= count_in;
            arrivals_ff <= arrivals_in;
         end

         if (insert_step) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload: accepted item, popped head, result word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff            <= req_tuser;
         item_ff.id       <= req_tdata[15:0];
         item_ff.age      <= req_tdata[22:16];
         item_ff.severity <= req_tdata[28:23];
         gap_ff           <= req_tdata[36:29];
         urgent_ff        <= req_tdata[37];
      end
      if (serve_step) begin
         served_slot_ff <= serve_now ? head_slot : '0;
      end
      if (insert_step) begin
         rsp_tdata_ff <= {2'b00, served_cnt_ff, arrivals_in, count_ext[6:0], full,
                          served_slot_ff.severity, served_slot_ff.age,
                          served_slot_ff.id, serve_ff};
      end
   end

   `SPQS_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SPQS_ASSERT_IMPLY(a_pop_on_arrival, serve_ff && state_ff == ST_INSERT, op_ff == OP_ARRIVAL)
   `SPQS_ASSERT_NEXT(a_serve_to_insert, state_ff == ST_SERVE, state_ff == ST_INSERT)
   `SPQS_ASSERT_NEXT(a_result_posted, insert_step, rsp_tvalid_ff)

endmodule

`default_nettype wire
